// ----- rtl/f16fr_pkg.sv -----
// Shared definitions for the Fletcher-16 frame receiver.
// Holds the result kind codes, field widths and the modulo-255 add helper.
// No dependencies.
package f16fr_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned CHECK_W = 16;
    localparam int unsigned KIND_W  = 2;
    // data_byte, byte_index, frame_length, computed_check, received_check
    localparam int unsigned RESULT_W = 3 * BYTE_W + 2 * CHECK_W;

    localparam logic [BYTE_W-1:0] SYNC_RESET = 8'h99;
    localparam logic [BYTE_W:0]   MOD_VALUE  = 9'd255;

    typedef enum logic [KIND_W-1:0] {
        KIND_PAYLOAD  = 2'd0,
        KIND_ACCEPT   = 2'd1,
        KIND_MISMATCH = 2'd2
    } result_kind_t;

    // Both operands stay below 256, so one conditional subtract reduces the sum.
    function automatic logic [BYTE_W-1:0] mod255_add(
        input logic [BYTE_W-1:0] a,
        input logic [BYTE_W-1:0] b
    );
        logic [BYTE_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= MOD_VALUE)
        begin
            s = s - MOD_VALUE;
        end
        return s[BYTE_W-1:0];
    endfunction

endpackage

// ----- rtl/fletcher16_frame_receiver.sv -----
// Fletcher-16 frame receiver: sync hunt, length, payload pass-through, check verdict.
// Depends on f16fr_pkg for kind codes, widths and the modulo-255 add.
// A result is registered and valid in the cycle after its causing byte is accepted.
// Throughput: one byte per cycle unless a held result stalls input (m_tready low);
// a new byte enters while the previous result is taken in the same cycle.
// Reset (rst_n low, asynchronous): hunt for sync, sums and counters cleared,
// sync value 0x99, no result pending.
module fletcher16_frame_receiver
(
    input  logic                           clk,
    input  logic                           rst_n,
    // Configuration: sync_value.
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [f16fr_pkg::BYTE_W-1:0]   cfg_data,
    // Slave side. tdata: rx_byte.
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [f16fr_pkg::BYTE_W-1:0]   s_tdata,
    // Master side. tdata from bit 0 up: data_byte, byte_index, frame_length,
    // computed_check, received_check. tuser: result_kind.
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [f16fr_pkg::RESULT_W-1:0] m_tdata,
    output logic [f16fr_pkg::KIND_W-1:0]   m_tuser
);
    import f16fr_pkg::*;

    typedef enum logic [1:0] {
        PH_SYNC  = 2'd0,
        PH_LEN   = 2'd1,
        PH_DATA  = 2'd2,
        PH_CHECK = 2'd3
    } phase_t;

    phase_t              phase_reg, phase_next;
    logic [BYTE_W-1:0]   sync_reg, sync_next;
    logic [BYTE_W-1:0]   length_reg, length_next;
    logic [BYTE_W-1:0]   count_reg, count_next;
    logic [BYTE_W-1:0]   sum_low_reg, sum_low_next;
    logic [BYTE_W-1:0]   sum_high_reg, sum_high_next;
    logic [BYTE_W-1:0]   check_low_reg, check_low_next;
    logic                check_seen_reg, check_seen_next;

    logic                out_valid_reg, out_valid_next;
    result_kind_t        out_kind_reg, out_kind_next;
    logic [BYTE_W-1:0]   out_byte_reg, out_byte_next;
    logic [BYTE_W-1:0]   out_index_reg, out_index_next;
    logic [BYTE_W-1:0]   out_length_reg, out_length_next;
    logic [CHECK_W-1:0]  out_computed_reg, out_computed_next;
    logic [CHECK_W-1:0]  out_received_reg, out_received_next;

    logic                in_fire;
    logic [BYTE_W-1:0]   base_low;
    logic [BYTE_W-1:0]   base_high;
    logic [BYTE_W-1:0]   fold_low;
    logic [BYTE_W-1:0]   fold_high;
    logic [BYTE_W-1:0]   count_inc;
    logic [CHECK_W-1:0]  computed;
    logic [CHECK_W-1:0]  received;

    assign cfg_ready = 1'b1;
    assign s_tready  = !out_valid_reg || m_tready;
    assign in_fire   = s_tvalid && s_tready;

    // A length byte restarts both sums from zero before it is folded in.
    assign base_low  = (phase_reg == PH_LEN) ? '0 : sum_low_reg;
    assign base_high = (phase_reg == PH_LEN) ? '0 : sum_high_reg;
    assign fold_low  = mod255_add(base_low, s_tdata);
    assign fold_high = mod255_add(base_high, fold_low);
    assign count_inc = count_reg + 1'b1;
    assign computed  = {sum_high_reg, sum_low_reg};
    assign received  = {s_tdata, check_low_reg};

    always_comb
    begin
        phase_next        = phase_reg;
        sync_next         = cfg_valid ? cfg_data : sync_reg;
        length_next       = length_reg;
        count_next        = count_reg;
        sum_low_next      = sum_low_reg;
        sum_high_next     = sum_high_reg;
        check_low_next    = check_low_reg;
        check_seen_next   = check_seen_reg;
        out_valid_next    = m_tready ? 1'b0 : out_valid_reg;
        out_kind_next     = out_kind_reg;
        out_byte_next     = out_byte_reg;
        out_index_next    = out_index_reg;
        out_length_next   = out_length_reg;
        out_computed_next = out_computed_reg;
        out_received_next = out_received_reg;

        if (in_fire)
        begin
            unique case (phase_reg)
                PH_SYNC:
                begin
                    if (s_tdata == sync_reg)
                    begin
                        phase_next = PH_LEN;
                    end
                end
                PH_LEN:
                begin
                    length_next     = s_tdata;
                    count_next      = '0;
                    sum_low_next    = fold_low;
                    sum_high_next   = fold_high;
                    check_low_next  = '0;
                    check_seen_next = 1'b0;
                    phase_next      = (s_tdata == '0) ? PH_CHECK : PH_DATA;
                end
                PH_DATA:
                begin
                    sum_low_next      = fold_low;
                    sum_high_next     = fold_high;
                    out_valid_next    = 1'b1;
                    out_kind_next     = KIND_PAYLOAD;
                    out_byte_next     = s_tdata;
                    out_index_next    = count_reg;
                    out_length_next   = length_reg;
                    out_computed_next = '0;
                    out_received_next = '0;
                    count_next        = count_inc;
                    if (count_inc == length_reg)
                    begin
                        phase_next = PH_CHECK;
                    end
                end
                PH_CHECK:
                begin
                    if (!check_seen_reg)
                    begin
                        check_low_next  = s_tdata;
                        check_seen_next = 1'b1;
                    end
                    else
                    begin
                        out_valid_next    = 1'b1;
                        out_kind_next     = (computed == received) ? KIND_ACCEPT
                                                                   : KIND_MISMATCH;
                        out_byte_next     = '0;
                        out_index_next    = '0;
                        out_length_next   = length_reg;
                        out_computed_next = computed;
                        out_received_next = received;
                        check_seen_next   = 1'b0;
                        phase_next        = PH_SYNC;
                    end
                end
                default:
                begin
                    phase_next = PH_SYNC;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_SYNC;
            sync_reg         <= SYNC_RESET;
            length_reg       <= '0;
            count_reg        <= '0;
            sum_low_reg      <= '0;
            sum_high_reg     <= '0;
            check_low_reg    <= '0;
            check_seen_reg   <= 1'b0;
            out_valid_reg    <= 1'b0;
            out_kind_reg     <= KIND_PAYLOAD;
            out_byte_reg     <= '0;
            out_index_reg    <= '0;
            out_length_reg   <= '0;
            out_computed_reg <= '0;
            out_received_reg <= '0;
        end
        else
        begin
            phase_reg        <= phase_next;
            sync_reg         <= sync_next;
            length_reg       <= length_next;
            count_reg        <= count_next;
            sum_low_reg      <= sum_low_next;
            sum_high_reg     <= sum_high_next;
            check_low_reg    <= check_low_next;
            check_seen_reg   <= check_seen_next;
            out_valid_reg    <= out_valid_next;
            out_kind_reg     <= out_kind_next;
            out_byte_reg     <= out_byte_next;
            out_index_reg    <= out_index_next;
            out_length_reg   <= out_length_next;
            out_computed_reg <= out_computed_next;
            out_received_reg <= out_received_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tdata  = {out_received_reg, out_computed_reg, out_length_reg,
                       out_index_reg, out_byte_reg};

endmodule
